### hw/rtl/spd_pkg.sv
package spd_pkg;

  // sample handling and datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int MIX_W       = 33;
  localparam int SMOOTH_W    = 32;
  localparam int LEVEL_W     = 16;
  localparam int RUN_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_ADDR_W  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_LOW  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_ON  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_OFF = 3'd5;

  // one mixed sample on its way from the front part to the filters
  typedef struct packed {
    logic signed [MIX_W-1:0] mix_i;
    logic signed [MIX_W-1:0] mix_q;
    logic                    frame_end;
  } mix_item_t;

  // decision thresholds and filter coefficient
  typedef struct packed {
    logic [23:0]        alpha;
    logic [LEVEL_W-1:0] level_high;
    logic [LEVEL_W-1:0] level_low;
    logic [RUN_W-1:0]   frames_on;
    logic [RUN_W-1:0]   frames_off;
  } dec_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DECIDE,
    ST_OUT
  } dec_state_t;

  // sine of j/2^lg quarter turns in unsigned Q0.15, taylor series in Q2.30
  function automatic logic [14:0] quarter_sine(input int unsigned j, input int unsigned lg);
    longint unsigned one;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    one = 64'd1 << 30;
    u   = longint'(j) << (30 - lg);
    x   = (u * 64'd1686629713) >> 30;
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - ((x2 * t) >> 30) / 156;
    t   = one - ((x2 * t) >> 30) / 110;
    t   = one - ((x2 * t) >> 30) / 72;
    t   = one - ((x2 * t) >> 30) / 42;
    t   = one - ((x2 * t) >> 30) / 20;
    t   = one - ((x2 * t) >> 30) / 6;
    s   = (x * t) >> 30;
    s   = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[14:0];
  endfunction

endpackage

### hw/rtl/spd_front.sv
module spd_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [31:0]               phase_step,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        pilot_i,
  input  logic signed [15:0]        pilot_q,
  input  logic                      frame_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spd_pkg::mix_item_t        out_item
);
  import spd_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int QN     = TABLE_DEPTH / 4;
  localparam int QIDX_W = IDX_W - 1;

  // quarter-wave table, built at elaboration
  logic [14:0] qtab [QN+1];
  for (genvar j = 0; j <= QN; j++) begin : g_qtab
    assign qtab[j] = quarter_sine(j, IDX_W - 2);
  end

  logic [31:0]        osc_phase;
  logic               v1, v2;
  logic signed [15:0] xi1, xq1, sin1, cos1;
  logic               fe1;
  logic               adv1, adv2;

  assign adv2      = !v2 || out_ready;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2;

  // table lookup with quadrant folding
  logic [IDX_W-1:0]  idx;
  logic [1:0]        quad, cquad;
  logic [QIDX_W-1:0] kq, refl;
  logic [14:0]       sin_mag, cos_mag;
  logic signed [15:0] sin_val, cos_val, xi_s, xq_s;

  always_comb begin
    idx     = osc_phase[31 -: IDX_W];
    quad    = idx[IDX_W-1 -: 2];
    cquad   = quad + 2'd1;
    kq      = {1'b0, idx[IDX_W-3:0]};
    refl    = QIDX_W'(QN) - kq;
    sin_mag = qtab[quad[0] ? refl : kq];
    cos_mag = qtab[cquad[0] ? refl : kq];
    sin_val = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    cos_val = cquad[1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    xi_s    = 16'($signed(pilot_i[SAMPLE_BITS-1:0])) <<< (16 - SAMPLE_BITS);
    xq_s    = 16'($signed(pilot_q[SAMPLE_BITS-1:0])) <<< (16 - SAMPLE_BITS);
  end

  // stage one: oscillator and sample capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      osc_phase <= '0;
    end else if (adv1) begin
      v1 <= in_valid;
      if (in_valid) begin
        osc_phase <= osc_phase + phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      xi1  <= xi_s;
      xq1  <= xq_s;
      fe1  <= frame_end;
      sin1 <= sin_val;
      cos1 <= cos_val;
    end
  end

  // stage two: complex mixer
  logic signed [31:0] p_ic, p_qs, p_is, p_qc;
  always_comb begin
    p_ic = xi1 * cos1;
    p_qs = xq1 * sin1;
    p_is = xi1 * sin1;
    p_qc = xq1 * cos1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      out_item.mix_i     <= $signed({p_ic[31], p_ic}) - $signed({p_qs[31], p_qs});
      out_item.mix_q     <= $signed({p_is[31], p_is}) + $signed({p_qc[31], p_qc});
      out_item.frame_end <= fe1;
    end
  end

endmodule

### hw/rtl/spd_queue.sv
module spd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spd_pkg::mix_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output spd_pkg::mix_item_t out_item
);
  import spd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mix_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign in_ready  = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### hw/rtl/spd_back.sv
module spd_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [23:0]                          alpha,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  spd_pkg::mix_item_t                   in_item,
  input  logic                                 dec_busy,
  output logic                                 start,
  output logic signed [spd_pkg::SMOOTH_W-1:0]  start_i,
  output logic signed [spd_pkg::SMOOTH_W-1:0]  start_q
);
  import spd_pkg::*;

  logic signed [SMOOTH_W-1:0] smooth_i, smooth_q;
  logic signed [SMOOTH_W-1:0] smooth_i_next, smooth_q_next;
  logic                       take;

  // one-pole update: s + round(alpha * (mix - s) / 2^24), clamped
  function automatic logic signed [SMOOTH_W-1:0] lowpass(
    input logic signed [SMOOTH_W-1:0] s,
    input logic signed [MIX_W-1:0]    mix,
    input logic [23:0]                a
  );
    logic signed [MIX_W:0]   d;
    logic signed [MIX_W+25:0] prod;
    logic signed [MIX_W+1:0] step;
    logic signed [MIX_W+1:0] sum;
    d    = $signed({mix[MIX_W-1], mix}) - $signed({{2{s[SMOOTH_W-1]}}, s});
    prod = $signed({1'b0, a}) * d;
    prod = prod + $signed((MIX_W+26)'(1) <<< 23);
    step = prod[MIX_W+25:24];
    sum  = $signed({{(MIX_W+2-SMOOTH_W){s[SMOOTH_W-1]}}, s}) + step;
    if (sum > $signed((MIX_W+2)'(32'h7FFF_FFFF)))
      return 32'sh7FFF_FFFF;
    else if (sum < -$signed((MIX_W+2)'(33'h0_8000_0000)))
      return 32'sh8000_0000;
    else
      return sum[SMOOTH_W-1:0];
  endfunction

  // a frame end waits until the decision unit is free
  assign in_ready = !in_item.frame_end || !dec_busy;
  assign take     = in_valid && in_ready;

  always_comb begin
    smooth_i_next = lowpass(smooth_i, in_item.mix_i, alpha);
    smooth_q_next = lowpass(smooth_q, in_item.mix_q, alpha);
  end

  assign start   = take && in_item.frame_end;
  assign start_i = smooth_i_next;
  assign start_q = smooth_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_i <= '0;
      smooth_q <= '0;
    end else if (take) begin
      smooth_i <= smooth_i_next;
      smooth_q <= smooth_q_next;
    end
  end

endmodule

### hw/rtl/spd_decide.sv
module spd_decide (
  input  logic                                clk,
  input  logic                                rst,
  input  spd_pkg::dec_cfg_t                   cfg,
  input  logic                                start,
  input  logic signed [spd_pkg::SMOOTH_W-1:0] start_i,
  input  logic signed [spd_pkg::SMOOTH_W-1:0] start_q,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                stereo_on,
  output logic [spd_pkg::LEVEL_W-1:0]         pilot_level
);
  import spd_pkg::*;

  dec_state_t state, state_next;

  logic signed [SMOOTH_W-1:0] vi, vq;
  logic [63:0]                sqi, sqq, v;
  logic [31:0]                res;
  logic [33:0]                rem;
  logic [4:0]                 cnt;
  logic [RUN_W-1:0]           high_run, low_run, high_run_next, low_run_next;
  logic                       flag, flag_next;
  logic signed [63:0]         pi, pq;
  logic [35:0]                rem_sh, trial;
  logic [LEVEL_W-1:0]         lvl;

  assign busy      = state != ST_IDLE;
  assign out_valid = state == ST_OUT;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (cnt == '0) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // squares and one root digit per cycle
  always_comb begin
    pi     = vi * vi;
    pq     = vq * vq;
    rem_sh = {rem, v[63:62]};
    trial  = {2'b00, res, 2'b01};
  end

  // level and hysteresis
  always_comb begin
    lvl           = (res[31]) ? '1 : res[30:15];
    high_run_next = high_run;
    low_run_next  = low_run;
    flag_next     = flag;
    if (lvl > cfg.level_high) begin
      low_run_next  = '0;
      high_run_next = (high_run == '1) ? high_run : high_run + 1'b1;
      if (high_run_next >= cfg.frames_on) flag_next = 1'b1;
    end else if (lvl < cfg.level_low) begin
      high_run_next = '0;
      low_run_next  = (low_run == '1) ? low_run : low_run + 1'b1;
      if (low_run_next >= cfg.frames_off) flag_next = 1'b0;
    end else begin
      high_run_next = '0;
      low_run_next  = '0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        vi <= start_i;
        vq <= start_q;
      end
      ST_SQUARE: begin
        sqi <= 64'(unsigned'(pi));
        sqq <= 64'(unsigned'(pq));
      end
      ST_SUM: begin
        v   <= sqi + sqq;
        res <= '0;
        rem <= '0;
        cnt <= 5'd31;
      end
      ST_ROOT: begin
        if (rem_sh >= trial) begin
          rem <= 34'(rem_sh - trial);
          res <= {res[30:0], 1'b1};
        end else begin
          rem <= rem_sh[33:0];
          res <= {res[30:0], 1'b0};
        end
        v   <= {v[61:0], 2'b00};
        cnt <= cnt - 1'b1;
      end
      ST_DECIDE: begin
        pilot_level <= lvl;
        stereo_on   <= flag_next;
      end
      default: begin
      end
    endcase
  end

  // run counters and stereo flag
  always_ff @(posedge clk) begin
    if (rst) begin
      high_run <= '0;
      low_run  <= '0;
      flag     <= 1'b0;
    end else if (state == ST_DECIDE) begin
      high_run <= high_run_next;
      low_run  <= low_run_next;
      flag     <= flag_next;
    end
  end

endmodule

### hw/rtl/stereo_pilot_detector.sv
// throughput: one pilot sample per cycle unless back-pressure stalls it;
// a frame end holds the decision unit until its result is taken (the square root
// gives one result bit per cycle), and later frame ends back up through the queue
// reset: synchronous; clears phase, filters, run counters and stereo flag, and
// loads the registers with their default values
module stereo_pilot_detector #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pilot_i [15:0], pilot_q [31:16]
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // stereo_on [0], pilot_level [16:1], zero [23:17]
);
  import spd_pkg::*;

  logic [31:0] phase_step;
  dec_cfg_t    cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= 32'd425022805;
      cfg.alpha      <= 24'd2196;
      cfg.level_high <= 16'd1966;
      cfg.level_low  <= 16'd983;
      cfg.frames_on  <= 16'd93;
      cfg.frames_off <= 16'd187;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PHASE_STEP: phase_step     <= cfg_data;
        CFG_ALPHA:      cfg.alpha      <= cfg_data[23:0];
        CFG_LEVEL_HIGH: cfg.level_high <= cfg_data[15:0];
        CFG_LEVEL_LOW:  cfg.level_low  <= cfg_data[15:0];
        CFG_FRAMES_ON:  cfg.frames_on  <= cfg_data[15:0];
        CFG_FRAMES_OFF: cfg.frames_off <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  mix_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_ready;
  logic      dec_busy, start;
  logic signed [SMOOTH_W-1:0] start_i, start_q;
  logic                       stereo_on;
  logic [LEVEL_W-1:0]         pilot_level;

  // oscillator and mixer
  spd_front #(.TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .phase_step(phase_step),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pilot_i   (s_tdata[15:0]),
    .pilot_q   (s_tdata[31:16]),
    .frame_end (s_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  // sample queue
  spd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  // lowpass filters
  spd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .alpha   (cfg.alpha),
    .in_valid(q_valid),
    .in_ready(q_ready),
    .in_item (q_item),
    .dec_busy(dec_busy),
    .start   (start),
    .start_i (start_i),
    .start_q (start_q)
  );

  // magnitude and hysteresis decision
  spd_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .start_i    (start_i),
    .start_q    (start_q),
    .busy       (dec_busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .stereo_on  (stereo_on),
    .pilot_level(pilot_level)
  );

  assign m_tdata = {7'd0, pilot_level, stereo_on};

endmodule
